>>> design/swsr_pkg.sv
// Shared constants for the shallow-water stencil residual block.
package swsr_pkg;

	localparam int DATA_WIDTH_DEF    = 32;
	localparam int FRACTION_BITS_DEF = 16;
	localparam int CFG_WIDTH         = 31;
	localparam int APB_ADDR_WIDTH    = 3;
	localparam int APB_DATA_WIDTH    = 32;

	// Register indexes, taken from the word address.
	localparam logic REG_SPACING = 1'b0;
	localparam logic REG_GRAVITY = 1'b1;

	localparam logic [CFG_WIDTH-1:0] SPACING_RESET = CFG_WIDTH'(65536);
	localparam logic [CFG_WIDTH-1:0] GRAVITY_RESET = CFG_WIDTH'(642253);

endpackage

>>> design/swsr_in_if.sv
// Input channel carrying one grid point per item.
interface swsr_in_if #(
	parameter int W = swsr_pkg::DATA_WIDTH_DEF
);
	logic                valid;
	logic                ready;
	logic signed [W-1:0] area;
	logic signed [W-1:0] discharge;
	logic signed [W-1:0] area_rate;
	logic signed [W-1:0] discharge_rate;
	logic                last_point;

	modport source (output valid, area, discharge, area_rate, discharge_rate, last_point,
		input ready);
	modport sink (input valid, area, discharge, area_rate, discharge_rate, last_point,
		output ready);
endinterface

>>> design/swsr_out_if.sv
// Output channel carrying one residual item per grid point.
interface swsr_out_if #(
	parameter int W = swsr_pkg::DATA_WIDTH_DEF
);
	logic                valid;
	logic                ready;
	logic signed [W-1:0] residual_area;
	logic signed [W-1:0] residual_discharge;
	logic                nonpositive_area;
	logic                last_result;

	modport source (output valid, residual_area, residual_discharge, nonpositive_area,
		last_result, input ready);
	modport sink (input valid, residual_area, residual_discharge, nonpositive_area,
		last_result, output ready);
endinterface

>>> design/shallow_water_stencil_residual.sv
// Saint-Venant central-difference residual for one row of grid points, one shared
// multiplier and one shared divider under a sequencer. The three radix-2
// divisions set most of the time of a residual: each takes one quotient bit per
// cycle, then gives a one-cycle done pulse. A residual whose centre area is not
// positive skips the arithmetic. An item that only becomes the held point gives
// no residual. Any other item is taken and then computed. A row's final point
// after a held point gives two residuals back to back. The block takes no item
// while a residual is being worked out, and a stalled output adds its stall to
// that time. A finished residual waits in the output register while the next
// item is taken.
module shallow_water_stencil_residual #(
	parameter int DATA_WIDTH    = swsr_pkg::DATA_WIDTH_DEF,
	parameter int FRACTION_BITS = swsr_pkg::FRACTION_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	swsr_in_if.sink                             in_item,
	swsr_out_if.source                          out_item,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [swsr_pkg::APB_ADDR_WIDTH-1:0] paddr,
	input  logic [swsr_pkg::APB_DATA_WIDTH-1:0] pwdata,
	output logic [swsr_pkg::APB_DATA_WIDTH-1:0] prdata,
	output logic                                pready
);
	import swsr_pkg::*;

	localparam int W  = DATA_WIDTH;
	localparam int F  = FRACTION_BITS;
	localparam int CW = CFG_WIDTH;
	localparam int MW = ((W > CW) ? W : CW) + 1;
	localparam int PW = 2 * MW;

	localparam logic signed [PW:0] SMAX = {{(PW+2-W){1'b0}}, {(W-1){1'b1}}};
	localparam logic signed [PW:0] SMIN = ~SMAX;
	localparam logic signed [PW:0] RND  = {{(PW+1-F){1'b0}}, {F{1'b1}}};

	localparam logic [4:0] ST_IDLE = 5'd0;
	localparam logic [4:0] ST_DIFF = 5'd1;
	localparam logic [4:0] ST_CDQ  = 5'd2;
	localparam logic [4:0] ST_RA   = 5'd3;
	localparam logic [4:0] ST_D1   = 5'd4;
	localparam logic [4:0] ST_W1   = 5'd5;
	localparam logic [4:0] ST_D2   = 5'd6;
	localparam logic [4:0] ST_W2   = 5'd7;
	localparam logic [4:0] ST_UDA  = 5'd8;
	localparam logic [4:0] ST_D3   = 5'd9;
	localparam logic [4:0] ST_W3   = 5'd10;
	localparam logic [4:0] ST_GA   = 5'd11;
	localparam logic [4:0] ST_GAD  = 5'd12;
	localparam logic [4:0] ST_T3   = 5'd13;
	localparam logic [4:0] ST_CI   = 5'd14;
	localparam logic [4:0] ST_RQ   = 5'd15;
	localparam logic [4:0] ST_OUT  = 5'd16;

	function automatic logic signed [W-1:0] sat(input logic signed [PW:0] x);
		logic signed [W-1:0] r;
		if (x > SMAX) r = SMAX[W-1:0];
		else if (x < SMIN) r = SMIN[W-1:0];
		else r = x[W-1:0];
		return r;
	endfunction

	function automatic logic signed [PW:0] wx(input logic signed [W-1:0] v);
		return {{(PW+1-W){v[W-1]}}, v};
	endfunction

	function automatic logic signed [MW-1:0] mx(input logic signed [W-1:0] v);
		return {{(MW-W){v[W-1]}}, v};
	endfunction

	function automatic logic signed [MW-1:0] cx(input logic [CW-1:0] v);
		return {{(MW-CW){1'b0}}, v};
	endfunction

	// Product back to the fraction point, truncated toward zero, then saturated.
	function automatic logic signed [W-1:0] fx(input logic signed [PW-1:0] p);
		logic signed [PW:0] e;
		e = {p[PW-1], p} + (p[PW-1] ? RND : '0);
		return sat(e >>> F);
	endfunction

	logic [CW-1:0] spacing_q;
	logic [CW-1:0] gravity_q;

	logic [4:0] state_q;
	logic       held_q;
	logic       second_q;

	logic signed [W-1:0] left_area_q, left_dis_q;
	logic signed [W-1:0] ctr_area_q, ctr_dis_q, ctr_arate_q, ctr_drate_q;

	logic signed [W-1:0] e_al_q, e_ql_q, e_ac_q, e_qc_q, e_ar_q, e_qr_q, e_an_q, e_qn_q;
	logic                e_last_q;

	logic signed [W-1:0] da_q, dq_q, ra_q, rq_q, tmp_q;
	logic signed [W:0]   acc_q;
	logic                npos_q;
	logic signed [PW-1:0] prod_q;

	logic                out_valid_q;
	logic signed [W-1:0] out_ra_q, out_rq_q;
	logic                out_npos_q, out_last_q;

	logic                 mul_en;
	logic signed [MW-1:0] mul_a, mul_b;
	logic                 div_start;
	logic signed [PW:0]   div_num;
	logic                 div_done;
	logic signed [W-1:0]  div_quot;
	logic                 in_acc;
	logic                 out_free;
	logic                 cfg_wr;

	// Configuration port.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == REG_GRAVITY) ? APB_DATA_WIDTH'(gravity_q)
		: APB_DATA_WIDTH'(spacing_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spacing_q <= SPACING_RESET;
			gravity_q <= GRAVITY_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_SPACING: spacing_q <= pwdata[CW-1:0];
				REG_GRAVITY: gravity_q <= pwdata[CW-1:0];
				default:     spacing_q <= spacing_q;
			endcase
		end
	end

	assign in_item.ready = (state_q == ST_IDLE);
	assign in_acc        = in_item.valid && in_item.ready;
	assign out_free      = !out_valid_q || out_item.ready;

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_en = 1'b0;
		mul_a  = '0;
		mul_b  = '0;
		case (state_q)
			ST_CDQ: begin
				mul_en = 1'b1; mul_a = cx(spacing_q); mul_b = mx(dq_q);
			end
			ST_RA: begin
				mul_en = 1'b1; mul_a = mx(e_qc_q); mul_b = mx(dq_q);
			end
			ST_D1: begin
				mul_en = 1'b1; mul_a = mx(e_qc_q); mul_b = mx(e_qc_q);
			end
			ST_UDA, ST_GAD: begin
				mul_en = 1'b1; mul_a = mx(tmp_q); mul_b = mx(da_q);
			end
			ST_W3: begin
				mul_en = div_done; mul_a = cx(gravity_q); mul_b = mx(e_ac_q);
			end
			ST_CI: begin
				mul_en = 1'b1; mul_a = cx(spacing_q); mul_b = mx(tmp_q);
			end
			default: mul_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mul_en) prod_q <= mul_a * mul_b;
	end

	// Divider start and dividend.
	always_comb begin
		div_start = 1'b0;
		div_num   = {prod_q[PW-1], prod_q};
		case (state_q)
			ST_D1: begin
				div_start = 1'b1; div_num = {prod_q, 1'b0};
			end
			ST_D2, ST_D3: div_start = 1'b1;
			default: div_start = 1'b0;
		endcase
	end

	swsr_div #(.W(W), .NW(PW + 1)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (e_ac_q),
		.done     (div_done),
		.quotient (div_quot)
	);

	// Sequencer control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			held_q      <= 1'b0;
			second_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// The output is marked full when a residual is loaded and empty once taken.
			if (state_q == ST_OUT && out_free) out_valid_q <= 1'b1;
			else if (out_item.ready) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (held_q) begin
							second_q <= in_item.last_point;
							state_q  <= ST_DIFF;
						end else if (in_item.last_point) begin
							held_q  <= 1'b0;
							state_q <= ST_DIFF;
						end else begin
							held_q <= 1'b1;
						end
					end
				end
				ST_DIFF: state_q <= (e_ac_q > 0) ? ST_CDQ : ST_OUT;
				ST_CDQ:  state_q <= ST_RA;
				ST_RA:   state_q <= ST_D1;
				ST_D1:   state_q <= ST_W1;
				ST_W1:   if (div_done) state_q <= ST_D2;
				ST_D2:   state_q <= ST_W2;
				ST_W2:   if (div_done) state_q <= ST_UDA;
				ST_UDA:  state_q <= ST_D3;
				ST_D3:   state_q <= ST_W3;
				ST_W3:   if (div_done) state_q <= ST_GA;
				ST_GA:   state_q <= ST_GAD;
				ST_GAD:  state_q <= ST_T3;
				ST_T3:   state_q <= ST_CI;
				ST_CI:   state_q <= ST_RQ;
				ST_RQ:   state_q <= ST_OUT;
				ST_OUT: begin
					if (out_free) begin
						if (second_q) begin
							second_q <= 1'b0;
							held_q   <= 1'b0;
							state_q  <= ST_DIFF;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Held points and the operands of the residual being worked out.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_area_q <= '0;
			left_dis_q  <= '0;
			ctr_area_q  <= '0;
			ctr_dis_q   <= '0;
			ctr_arate_q <= '0;
			ctr_drate_q <= '0;
		end else if (in_acc) begin
			if (held_q) begin
				left_area_q <= ctr_area_q;
				left_dis_q  <= ctr_dis_q;
			end else begin
				left_area_q <= in_item.area;
				left_dis_q  <= in_item.discharge;
			end
			ctr_area_q  <= in_item.area;
			ctr_dis_q   <= in_item.discharge;
			ctr_arate_q <= in_item.area_rate;
			ctr_drate_q <= in_item.discharge_rate;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			e_an_q <= in_item.area;
			e_qn_q <= in_item.discharge;
			if (held_q) begin
				e_al_q   <= left_area_q;
				e_ql_q   <= left_dis_q;
				e_ac_q   <= ctr_area_q;
				e_qc_q   <= ctr_dis_q;
				e_ar_q   <= ctr_arate_q;
				e_qr_q   <= ctr_drate_q;
				e_last_q <= 1'b0;
			end else begin
				e_al_q   <= in_item.area;
				e_ql_q   <= in_item.discharge;
				e_ac_q   <= in_item.area;
				e_qc_q   <= in_item.discharge;
				e_ar_q   <= in_item.area_rate;
				e_qr_q   <= in_item.discharge_rate;
				e_last_q <= 1'b1;
			end
		end else if (state_q == ST_OUT && out_free && second_q) begin
			// The row's final point, with itself as the right-hand ghost.
			e_al_q   <= left_area_q;
			e_ql_q   <= left_dis_q;
			e_ac_q   <= ctr_area_q;
			e_qc_q   <= ctr_dis_q;
			e_ar_q   <= ctr_arate_q;
			e_qr_q   <= ctr_drate_q;
			e_an_q   <= ctr_area_q;
			e_qn_q   <= ctr_dis_q;
			e_last_q <= 1'b1;
		end
	end

	// Datapath registers of the residual steps.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_DIFF: begin
				da_q   <= sat(wx(e_an_q) - wx(e_al_q));
				dq_q   <= sat(wx(e_qn_q) - wx(e_ql_q));
				npos_q <= !(e_ac_q > 0);
				ra_q   <= '0;
				rq_q   <= '0;
			end
			ST_RA:  ra_q <= sat(wx(e_ar_q) + wx(fx(prod_q)));
			ST_W1:  if (div_done) acc_q <= {div_quot[W-1], div_quot};
			ST_W2:  if (div_done) tmp_q <= div_quot;
			ST_W3:  if (div_done) acc_q <= acc_q - {div_quot[W-1], div_quot};
			ST_GA:  tmp_q <= fx(prod_q);
			ST_T3:  tmp_q <= sat({{(PW-W){acc_q[W]}}, acc_q} + wx(fx(prod_q)));
			ST_RQ:  rq_q <= sat(wx(e_qr_q) + wx(fx(prod_q)));
			default: tmp_q <= tmp_q;
		endcase
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			out_ra_q   <= ra_q;
			out_rq_q   <= rq_q;
			out_npos_q <= npos_q;
			out_last_q <= e_last_q;
		end
	end

	assign out_item.valid              = out_valid_q;
	assign out_item.residual_area      = out_ra_q;
	assign out_item.residual_discharge = out_rq_q;
	assign out_item.nonpositive_area   = out_npos_q;
	assign out_item.last_result        = out_last_q;

endmodule

>>> design/swsr_div.sv
// Radix-2 restoring divider with saturation of the quotient to the data width.
module swsr_div #(
	parameter int W  = 32,
	parameter int NW = 67
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [NW-1:0] dividend,
	input  logic        [W-1:0]  divisor,
	output logic                 done,
	output logic signed [W-1:0]  quotient
);
	localparam int CNTW = (W > 1) ? $clog2(W) : 1;

	logic            run_q;
	logic            done_q;
	logic [CNTW-1:0] cnt_q;
	logic            neg_q;
	logic            ovf_q;
	logic [W-1:0]    rem_q;
	logic [W-1:0]    lo_q;

	logic [NW-1:0]   mag;
	logic [NW-W-1:0] mag_hi;
	logic [W:0]      rem_sh;
	logic            fits;
	logic [W-1:0]    lim;
	logic [W-1:0]    qmag;

	// Magnitude of the dividend and the overflow test on its upper part.
	assign mag    = dividend[NW-1] ? NW'(-dividend) : NW'(dividend);
	assign mag_hi = mag[NW-1:W];
	assign rem_sh = {rem_q, lo_q[W-1]};
	assign fits   = rem_sh >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNTW'(W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// One quotient bit each cycle; the quotient shifts in behind the dividend bits.
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[NW-1];
			ovf_q <= mag_hi >= (NW-W)'(divisor);
			rem_q <= mag_hi[W-1:0];
			lo_q  <= mag[W-1:0];
		end else if (run_q) begin
			rem_q <= fits ? W'(rem_sh - {1'b0, divisor}) : rem_sh[W-1:0];
			lo_q  <= {lo_q[W-2:0], fits};
		end
	end

	// Saturate the magnitude and restore the sign.
	assign lim      = neg_q ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
	assign qmag     = (ovf_q || lo_q > lim) ? lim : lo_q;
	assign quotient = neg_q ? $signed(W'(-qmag)) : $signed(qmag);
	assign done     = done_q;

endmodule

>>> sim/swsr_residual_checker.sv
// Checker for the stencil residual block: predicts residuals and compares them.
module swsr_residual_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	swsr_in_if                                  in_ch,
	swsr_out_if                                 out_ch,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [swsr_pkg::APB_ADDR_WIDTH-1:0] paddr,
	input  logic [swsr_pkg::APB_DATA_WIDTH-1:0] pwdata,
	input  logic                                pready,
	output int                                  pending,
	output int                                  errors,
	output int                                  residuals_seen,
	output int                                  flagged_seen
);
	import swsr_pkg::*;

	typedef logic signed [191:0] exact_t;
	typedef logic signed [31:0] word_t;

	typedef struct packed {
		word_t residual_area;
		word_t residual_discharge;
		logic  nonpositive_area;
		logic  last_result;
	} residual_t;

	localparam exact_t WORD_MAX = exact_t'(32'sh7fffffff);
	localparam exact_t WORD_MIN = exact_t'(32'sh80000000);

	residual_t expected_residuals[$];

	logic [CFG_WIDTH-1:0] spacing;
	logic [CFG_WIDTH-1:0] gravity;

	logic  centre_held;
	word_t centre_area, centre_discharge, centre_area_rate, centre_discharge_rate;
	word_t left_area, left_discharge;

	assign pending = expected_residuals.size();

	// Clamp an exact value to the signed data word.
	function automatic exact_t clamp_word(exact_t x);
		if (x > WORD_MAX)
			return WORD_MAX;
		if (x < WORD_MIN)
			return WORD_MIN;
		return x;
	endfunction

	// Fixed-point product, truncated toward zero, then saturated.
	function automatic exact_t fixed_product(exact_t x, exact_t y);
		exact_t p;
		p = x * y;
		if (p < 0)
			p = -((-p) >>> FRACTION_BITS_DEF);
		else
			p = p >>> FRACTION_BITS_DEF;
		return clamp_word(p);
	endfunction

	// Residual of one centre point given its two neighbours.
	function automatic residual_t stencil_residual(word_t al, word_t ql, word_t ac, word_t qc,
			word_t ar, word_t qr, word_t an, word_t qn, logic last);
		residual_t r;
		exact_t c, g, a, q, da, dq, t1, u, t2, t3, inner;
		c = exact_t'(spacing);
		g = exact_t'(gravity);
		r.last_result = last;
		if (ac <= 0) begin
			r.residual_area = '0;
			r.residual_discharge = '0;
			r.nonpositive_area = 1'b1;
			return r;
		end
		a = exact_t'(ac);
		q = exact_t'(qc);
		da = clamp_word(exact_t'(an) - exact_t'(al));
		dq = clamp_word(exact_t'(qn) - exact_t'(ql));
		r.residual_area = word_t'(clamp_word(exact_t'(ar) + fixed_product(c, dq)));
		t1 = clamp_word((2 * q * dq) / a);
		u = clamp_word((q * q) / a);
		t2 = clamp_word((u * da) / a);
		t3 = fixed_product(fixed_product(g, a), da);
		inner = clamp_word(t1 - t2 + t3);
		r.residual_discharge = word_t'(clamp_word(exact_t'(qr) + fixed_product(c, inner)));
		r.nonpositive_area = 1'b0;
		return r;
	endfunction

	// Count one mismatch and print its line for the first 30.
	task automatic report_mismatch(string what);
		errors++;
		if (errors <= 30)
			$display("%0t: residual mismatch: %s", $realtime, what);
	endtask

	// Track the register file, compare results, then take in new points.
	always @(posedge clk or negedge arst_n) begin
		residual_t got, want;
		if (!arst_n) begin
			spacing <= SPACING_RESET;
			gravity <= GRAVITY_RESET;
			centre_held <= 1'b0;
			centre_area <= '0;
			centre_discharge <= '0;
			centre_area_rate <= '0;
			centre_discharge_rate <= '0;
			left_area <= '0;
			left_discharge <= '0;
			expected_residuals.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_SPACING)
					spacing <= pwdata[CFG_WIDTH-1:0];
				else
					gravity <= pwdata[CFG_WIDTH-1:0];
			end

			if (out_ch.valid && out_ch.ready) begin
				got = '{out_ch.residual_area, out_ch.residual_discharge,
					out_ch.nonpositive_area, out_ch.last_result};
				residuals_seen++;
				if (got.nonpositive_area)
					flagged_seen++;
				if (expected_residuals.size() == 0) begin
					report_mismatch($sformatf("unexpected item %h", got));
				end else begin
					want = expected_residuals.pop_front();
					if (got.residual_area !== want.residual_area)
						report_mismatch($sformatf("residual_area %h, want %h",
							got.residual_area, want.residual_area));
					if (got.residual_discharge !== want.residual_discharge)
						report_mismatch($sformatf("residual_discharge %h, want %h",
							got.residual_discharge, want.residual_discharge));
					if (got.nonpositive_area !== want.nonpositive_area)
						report_mismatch($sformatf("nonpositive_area %b, want %b",
							got.nonpositive_area, want.nonpositive_area));
					if (got.last_result !== want.last_result)
						report_mismatch($sformatf("last_result %b, want %b",
							got.last_result, want.last_result));
				end
			end

			if (in_ch.valid && in_ch.ready) begin
				word_t nl_area, nl_discharge;
				nl_area = in_ch.area;
				nl_discharge = in_ch.discharge;
				if (centre_held) begin
					expected_residuals.push_back(stencil_residual(left_area, left_discharge,
						centre_area, centre_discharge, centre_area_rate,
						centre_discharge_rate, in_ch.area, in_ch.discharge, 1'b0));
					nl_area = centre_area;
					nl_discharge = centre_discharge;
				end
				if (in_ch.last_point)
					expected_residuals.push_back(stencil_residual(nl_area, nl_discharge,
						in_ch.area, in_ch.discharge, in_ch.area_rate, in_ch.discharge_rate,
						in_ch.area, in_ch.discharge, 1'b1));
				left_area <= nl_area;
				left_discharge <= nl_discharge;
				centre_area <= in_ch.area;
				centre_discharge <= in_ch.discharge;
				centre_area_rate <= in_ch.area_rate;
				centre_discharge_rate <= in_ch.discharge_rate;
				centre_held <= !in_ch.last_point;
			end
		end
	end

	initial begin
		errors = 0;
		residuals_seen = 0;
		flagged_seen = 0;
	end

endmodule

>>> sim/tb_shallow_water_stencil_residual.sv
// Testbench top: drives rows of grid points and register settings, gives the verdict.
module tb_shallow_water_stencil_residual;
	import swsr_pkg::*;

	localparam int STALL_LIMIT = 6000;
	localparam int HOLD_OFF    = 800;
	localparam int SETTLE      = 250;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite, pready;
	logic [APB_ADDR_WIDTH-1:0] paddr;
	logic [APB_DATA_WIDTH-1:0] pwdata, prdata;

	int pending, errors, residuals_seen, flagged_seen;
	int points_sent, rows_sent, settings_used;
	int idle_cycles;
	bit quiet;
	bit hold_request;

	swsr_in_if  in_ch();
	swsr_out_if out_ch();

	shallow_water_stencil_residual u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_item (in_ch),
		.out_item(out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	swsr_residual_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_ch         (in_ch),
		.out_ch        (out_ch),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.pready        (pready),
		.pending       (pending),
		.errors        (errors),
		.residuals_seen(residuals_seen),
		.flagged_seen  (flagged_seen)
	);

	// Clock with a period of 12.
	always begin
		#6 clk = 1'b1;
		#6 clk = 0;
	end

	// Receiver: random stall bursts, one long hold-off on request, none when quiet.
	always begin
		@(negedge clk);
		if (hold_request) begin
			out_ch.ready = 1'b0;
			repeat (HOLD_OFF) @(negedge clk);
			hold_request = 1'b0;
		end else if (!quiet && $urandom_range(0, 7) == 0) begin
			out_ch.ready = 1'b0;
			repeat ($urandom_range(1, 13)) @(negedge clk);
		end
		out_ch.ready = 1'b1;
	end

	// Watchdog on cycles in which no item moves.
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("tb_shallow_water_stencil_residual: errors");
			$finish;
		end
	end

	// Offer one grid point, with a random idle burst in front of it.
	task automatic offer_point(input logic [31:0] a, q, ar, qr, input logic lp);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			in_ch.valid = 1'b0;
			repeat ($urandom_range(1, 13)) @(negedge clk);
		end
		in_ch.area = a;
		in_ch.discharge = q;
		in_ch.area_rate = ar;
		in_ch.discharge_rate = qr;
		in_ch.last_point = lp;
		in_ch.valid = 1'b1;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		@(negedge clk);
		points_sent++;
		if (lp)
			rows_sent++;
	endtask

	// Stop offering, wait until every residual has come, then let the bench settle.
	task automatic drain;
		in_ch.valid = 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	// Register write: setup cycle then access cycle.
	task automatic write_register(input logic idx, input logic [30:0] value);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = APB_ADDR_WIDTH'({idx, 2'b00});
		pwdata = {1'($urandom_range(0, 1)), value};
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	// One row of random length, mostly physically sensible points.
	task automatic random_row(input int max_len);
		int len;
		logic [31:0] a, q, ar, qr;
		len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, max_len);
		for (int i = 0; i < len; i++) begin
			case ($urandom_range(0, 9))
				0: begin
					a = $urandom;
					q = $urandom;
					ar = $urandom;
					qr = $urandom;
				end
				1: begin
					a = ($urandom_range(0, 1) != 0) ? 32'h0 : -$urandom_range(1, 32'h7fffff);
					q = $urandom;
					ar = $urandom;
					qr = $urandom;
				end
				2: begin
					a = $urandom_range(1, 32'hff);
					q = $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
					ar = $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
					qr = $urandom;
				end
				default: begin
					a = $urandom_range(32'h4000, 32'h7fffff);
					q = $urandom_range(0, 32'h3ffffff) - 32'h1ffffff;
					ar = $urandom_range(0, 32'h3fffff) - 32'h1fffff;
					qr = $urandom_range(0, 32'h3fffff) - 32'h1fffff;
				end
			endcase
			offer_point(a, q, ar, qr, i == len - 1);
		end
	endtask

	// Stimulus: directed rows, then random rows under a series of register settings.
	initial begin
		logic [30:0] spacing_set[6];
		logic [30:0] gravity_set[6];
		clk = 0;
		arst_n = 0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = '0;
		pwdata = '0;
		in_ch.valid = 0;
		in_ch.area = '0;
		in_ch.discharge = '0;
		in_ch.area_rate = '0;
		in_ch.discharge_rate = '0;
		in_ch.last_point = 0;
		out_ch.ready = 0;
		quiet = 0;
		hold_request = 0;
		idle_cycles = 0;
		points_sent = 0;
		rows_sent = 0;
		settings_used = 1;
		spacing_set = '{31'h0, 31'h7fffffff, 31'h1, 31'h40000, 31'h4000, 31'h10000};
		gravity_set = '{31'h0, 31'h7fffffff, 31'h1, 31'h9ccd, 31'h1ffffff, 31'h9ccd};
		repeat (5) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Directed part under the reset settings.
		offer_point(32'h10000, 32'h20000, 32'h7fffffff, 32'h80000000, 1);
		offer_point(32'h7fffffff, 32'h7fffffff, 32'h0, 32'h0, 0);
		offer_point(32'h80000000, 32'h80000000, 32'h1, 32'hffffffff, 0);
		offer_point(32'h0, 32'h0, 32'h0, 32'h0, 0);
		offer_point(32'h1, 32'hffffffff, 32'h7fffffff, 32'h7fffffff, 0);
		offer_point(32'hffffffff, 32'h7fffffff, 32'h80000000, 32'h80000000, 1);
		offer_point(32'h1, 32'h7fffffff, 32'h0, 32'h0, 0);
		offer_point(32'h1, 32'h80000000, 32'h0, 32'h0, 0);
		offer_point(32'h10000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 1);
		offer_point(32'h20000, 32'h8000, 32'h100, 32'hffffff00, 0);
		offer_point(32'h28000, 32'h9000, 32'h0, 32'h0, 0);
		offer_point(32'h30000, 32'ha000, 32'hfffff000, 32'h1000, 0);
		offer_point(32'h7fffffff, 32'h80000000, 32'h0, 32'h0, 1);
		offer_point(32'h0, 32'h7fffffff, 32'h5555aaaa, 32'haaaa5555, 1);
		drain();

		// Long hold-off on the receiver while points keep coming.
		hold_request = 1;
		for (int r = 0; r < 4; r++)
			random_row(8);
		drain();

		// Random rows under each register setting; the last stretch without idling.
		for (int s = 0; s < 6; s++) begin
			write_register(REG_SPACING, spacing_set[s]);
			write_register(REG_GRAVITY, gravity_set[s]);
			settings_used++;
			if (s == 5)
				quiet = 1;
			while (points_sent < 40 + (s + 1) * 280)
				random_row(12);
			drain();
		end

		$display("Sent %0d grid points in %0d rows over %0d register settings.",
			points_sent, rows_sent, settings_used);
		$display("Checked %0d residuals, %0d of them with a nonpositive area.",
			residuals_seen, flagged_seen);
		if (errors == 0)
			$display("tb_shallow_water_stencil_residual: clean");
		else
			$display("tb_shallow_water_stencil_residual: errors");
		$finish;
	end

endmodule
